/* rtl/laser_safety_fault_monitor_assert.svh */
// ---------------------------------------------------------------------------
// Laser safety fault monitor assertion macros
// Shared property wrappers; clock and reset are the enclosing scope's
// clock and reset.
// ---------------------------------------------------------------------------
`ifndef LASER_SAFETY_FAULT_MONITOR_ASSERT_SVH
`define LASER_SAFETY_FAULT_MONITOR_ASSERT_SVH

// same-cycle implication
`define LSFM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LSFM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/lsfm_pkg.sv */
// ---------------------------------------------------------------------------
// lsfm_pkg
// Types and fixed constants shared by the laser safety fault monitor.
// ---------------------------------------------------------------------------
package lsfm_pkg;

   localparam int FLAME_W    = 12;
   localparam int ANGLE_W    = 9;
   localparam int TEMP_W     = 9;
   localparam int FAULT_W    = 6;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // fire flag hold time in seconds
   localparam int HOLD_SECONDS = 5;

   // fault word bit positions
   localparam int FB_TEMP = 0;
   localparam int FB_ATT  = 1;
   localparam int FB_FAN  = 2;
   localparam int FB_FIRE = 3;
   localparam int FB_PIN  = 4;
   localparam int FB_IMU  = 5;

   // response queue
   localparam int RSP_FIFO_DEPTH = 8;
   localparam int RSP_CNT_W      = $clog2(RSP_FIFO_DEPTH + 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PROTECT_TEMP   = 4'd0,
      CSR_RECOVERY_TEMP  = 4'd1,
      CSR_FIRE_THRESHOLD = 4'd2,
      CSR_ROLL_LOW       = 4'd3,
      CSR_ROLL_HIGH      = 4'd4,
      CSR_PITCH_LOW      = 4'd5,
      CSR_PITCH_HIGH     = 4'd6,
      CSR_IMU_ABSENT     = 4'd7
   } csr_index_type;

   typedef struct packed {
      logic [7:0]                protect_temp;
      logic [7:0]                recovery_temp;
      logic [15:0]               fire_threshold;
      logic signed [ANGLE_W-1:0] roll_low;
      logic signed [ANGLE_W-1:0] roll_high;
      logic signed [ANGLE_W-1:0] pitch_low;
      logic signed [ANGLE_W-1:0] pitch_high;
      logic                      imu_absent;
   } cfg_type;

   // per-sample fields that ride along with the window pipeline
   typedef struct packed {
      logic signed [TEMP_W-1:0]  head_temp;
      logic signed [ANGLE_W-1:0] pitch_deg;
      logic signed [ANGLE_W-1:0] roll_deg;
      logic                      attitude_valid;
      logic                      fan_ok;
      logic                      pin_confirm;
   } item_type;

   // window pipeline -> fault stage
   typedef struct packed {
      logic               valid;
      logic [FLAME_W-1:0] avg;
      item_type           item;
   } avg_stage_type;

   typedef struct packed {
      logic [FAULT_W-1:0] fault_word;
      logic               force_off;
      logic               fault_changed;
      logic               fire_flag;
      logic [FLAME_W-1:0] flame_average;
   } rsp_type;

endpackage

/* rtl/laser_safety_fault_monitor.sv */
// ---------------------------------------------------------------------------
// laser_safety_fault_monitor
// Laser head safety monitor: one request word per sample period in, one
// response word out. Each response carries the six-bit fault word (bit0
// over-temperature with hysteresis, bit1 attitude outside the pitch/roll
// window, bit2 fan, bit3 fire, bit4 unconfirmed PWM pin, bit5 IMU absent),
// force_off when any bit is set, fault_changed when the word differs from
// the previous one, the held fire flag and the flame moving average. The
// fire bit in the fault word is the flag as it stood before this sample, so
// it trails rsp_fire_flag by one word. Fire detection starts with word
// WARMUP_SAMPLES and a raised flag is held for 5 * SAMPLE_RATE words;
// a threshold above THRESHOLD_LIMIT disables detection. Throughput is one
// word per clock while req_ready is high: the window RAM takes one
// read and one write per word. An eight word response queue lets
// requests keep flowing while the consumer stalls; req_ready drops only
// when the queue plus the three pipeline stages would overflow. No
// clearing pass after reset: unwritten window slots read as zero until
// the first wrap. CSR writes only while idle.
// ---------------------------------------------------------------------------
module laser_safety_fault_monitor import lsfm_pkg::*; #(
   parameter int WINDOW_DEPTH    = 64,
   parameter int WARMUP_SAMPLES  = 380,
   parameter int SAMPLE_RATE     = 100,
   parameter int THRESHOLD_LIMIT = 4000
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [FLAME_W-1:0]        req_flame_sample,
   input  logic signed [TEMP_W-1:0]  req_head_temp,
   input  logic signed [ANGLE_W-1:0] req_pitch_deg,
   input  logic signed [ANGLE_W-1:0] req_roll_deg,
   input  logic                      req_attitude_valid,
   input  logic                      req_fan_ok,
   input  logic                      req_pin_confirm,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [FAULT_W-1:0]        rsp_fault_word,
   output logic                      rsp_force_off,
   output logic                      rsp_fault_changed,
   output logic                      rsp_fire_flag,
   output logic [FLAME_W-1:0]        rsp_flame_average,
   // configuration write port
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_wdata
);

   localparam cfg_type CFG_RESET = '{
      protect_temp:   8'd55,
      recovery_temp:  8'd45,
      fire_threshold: 16'd1000,
      roll_low:       -9'sd45,
      roll_high:      9'sd45,
      pitch_low:      -9'sd45,
      pitch_high:     9'sd45,
      imu_absent:     1'b0
   };

   cfg_type                cfg_ff, cfg_in;
   logic                   req_fire;
   logic                   rsp_fire;
   item_type               req_item;
   avg_stage_type          avg_stage;
   logic [1:0]             busy_count;
   logic                   rsp_push;
   rsp_type                rsp_word;
   rsp_type                rsp_out;
   logic [RSP_CNT_W-1:0]   rsp_count;
   logic [RSP_CNT_W:0]     occupancy;

   // --- configuration registers -------------------------------------------
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_PROTECT_TEMP:   cfg_in.protect_temp   = csr_wdata[7:0];
            CSR_RECOVERY_TEMP:  cfg_in.recovery_temp  = csr_wdata[7:0];
            CSR_FIRE_THRESHOLD: cfg_in.fire_threshold = csr_wdata;
            CSR_ROLL_LOW:       cfg_in.roll_low       = csr_wdata[ANGLE_W-1:0];
            CSR_ROLL_HIGH:      cfg_in.roll_high      = csr_wdata[ANGLE_W-1:0];
            CSR_PITCH_LOW:      cfg_in.pitch_low      = csr_wdata[ANGLE_W-1:0];
            CSR_PITCH_HIGH:     cfg_in.pitch_high     = csr_wdata[ANGLE_W-1:0];
            CSR_IMU_ABSENT:     cfg_in.imu_absent     = csr_wdata[0];
            default:            cfg_in = cfg_ff;     // unmapped index: ignored
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // --- request side ------------------------------------------------------
   // Credit check: words in the three window stages plus queued words must
   // leave room for one more, so the queue can never overflow.
   assign occupancy = {1'b0, rsp_count} + (RSP_CNT_W + 1)'(busy_count);
   assign req_ready = (occupancy < (RSP_CNT_W + 1)'(RSP_FIFO_DEPTH));
   assign req_fire  = req_valid & req_ready;

   assign req_item.head_temp      = req_head_temp;
   assign req_item.pitch_deg      = req_pitch_deg;
   assign req_item.roll_deg       = req_roll_deg;
   assign req_item.attitude_valid = req_attitude_valid;
   assign req_item.fan_ok         = req_fan_ok;
   assign req_item.pin_confirm    = req_pin_confirm;

   // --- moving-average window (RAM, running sum, divide) ------------------
   lsfm_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_fire),
      .in_sample  (req_flame_sample),
      .in_item    (req_item),
      .avg_stage  (avg_stage),
      .busy_count (busy_count)
   );

   // --- fault word and fire detector --------------------------------------
   lsfm_fault #(
      .WARMUP_SAMPLES  (WARMUP_SAMPLES),
      .SAMPLE_RATE     (SAMPLE_RATE),
      .THRESHOLD_LIMIT (THRESHOLD_LIMIT)
   ) u_fault (
      .clock     (clock),
      .reset     (reset),
      .avg_stage (avg_stage),
      .cfg       (cfg_ff),
      .rsp_push  (rsp_push),
      .rsp_word  (rsp_word)
   );

   // --- response queue ----------------------------------------------------
   assign rsp_fire = rsp_valid & rsp_ready;

   lsfm_rsp_fifo #(
      .DEPTH (RSP_FIFO_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_word),
      .pop       (rsp_fire),
      .out_valid (rsp_valid),
      .out_data  (rsp_out),
      .count     (rsp_count)
   );

   assign rsp_fault_word    = rsp_out.fault_word;
   assign rsp_force_off     = rsp_out.force_off;
   assign rsp_fault_changed = rsp_out.fault_changed;
   assign rsp_fire_flag     = rsp_out.fire_flag;
   assign rsp_flame_average = rsp_out.flame_average;

endmodule

/* rtl/lsfm_ram.sv */
// ---------------------------------------------------------------------------
// lsfm_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ---------------------------------------------------------------------------
module lsfm_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/lsfm_window.sv */
// ---------------------------------------------------------------------------
// lsfm_window
// Moving-average window: sample RAM, running sum, reciprocal divide.
// ---------------------------------------------------------------------------
module lsfm_window import lsfm_pkg::*; #(
   parameter int WINDOW_DEPTH = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic [FLAME_W-1:0] in_sample,
   input  item_type           in_item,
   output avg_stage_type      avg_stage,
   output logic [1:0]         busy_count
);

   localparam int PTR_W  = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = FLAME_W + PTR_W;
   localparam int SHIFT  = SUM_W + PTR_W;
   localparam int REC_W  = SHIFT - PTR_W + 2;
   localparam int PROD_W = SUM_W + REC_W;
   // ceil(2^SHIFT / depth): exact floor quotient for every sum value
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(WINDOW_DEPTH) - 64'd1) / 64'(WINDOW_DEPTH);
   localparam logic [REC_W-1:0] RECIP     = REC_W'(RECIP_FULL);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(WINDOW_DEPTH - 1);

   logic [PTR_W-1:0]   ptr_ff, ptr_in;
   logic               wrapped_ff, wrapped_in;
   logic               s1_valid_ff;
   logic [PTR_W-1:0]   s1_ptr_ff;
   logic               s1_old_ok_ff;
   logic [FLAME_W-1:0] s1_sample_ff;
   item_type           s1_item_ff;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               s2_valid_ff;
   logic [SUM_W-1:0]   s2_sum_ff;
   item_type           s2_item_ff;
   logic               s3_valid_ff;
   logic [PROD_W-1:0]  s3_prod_ff;
   item_type           s3_item_ff;
   logic [FLAME_W-1:0] rd_data;
   logic [FLAME_W-1:0] old_sample;

   // slot is read at accept and rewritten in the next cycle; the same slot is
   // read again no earlier than depth (>= 2) words later, so no bypass
   lsfm_ram #(
      .WIDTH (FLAME_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_ptr_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (in_valid),
      .rd_addr (ptr_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      ptr_in     = ptr_ff;
      wrapped_in = wrapped_ff;
      if (in_valid) begin
         if (ptr_ff == LAST_SLOT) begin
            ptr_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            ptr_in = ptr_ff + 1'b1;
         end
      end
   end

   // slots not yet written on the first pass count as zero
   assign old_sample = s1_old_ok_ff ? rd_data : '0;

   always_comb begin
      sum_in = sum_ff;
      if (s1_valid_ff) begin
         sum_in = sum_ff - SUM_W'(old_sample) + SUM_W'(s1_sample_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff      <= '0;
         wrapped_ff  <= 1'b0;
         sum_ff      <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         ptr_ff      <= ptr_in;
         wrapped_ff  <= wrapped_in;
         sum_ff      <= sum_in;
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_ptr_ff    <= ptr_ff;
      s1_old_ok_ff <= wrapped_ff;
      s1_sample_ff <= in_sample;
      s1_item_ff   <= in_item;
      s2_sum_ff    <= sum_in;
      s2_item_ff   <= s1_item_ff;
      s3_prod_ff   <= PROD_W'(s2_sum_ff) * PROD_W'(RECIP);
      s3_item_ff   <= s2_item_ff;
   end

   assign avg_stage.valid = s3_valid_ff;
   assign avg_stage.avg   = s3_prod_ff[SHIFT +: FLAME_W];
   assign avg_stage.item  = s3_item_ff;

   assign busy_count = {1'b0, s1_valid_ff} + {1'b0, s2_valid_ff} + {1'b0, s3_valid_ff};

endmodule

/* rtl/lsfm_fault.sv */
// ---------------------------------------------------------------------------
// lsfm_fault
// Fault word evaluation and flame detector hold logic.
// ---------------------------------------------------------------------------
module lsfm_fault import lsfm_pkg::*; #(
   parameter int WARMUP_SAMPLES  = 380,
   parameter int SAMPLE_RATE     = 100,
   parameter int THRESHOLD_LIMIT = 4000
) (
   input  logic          clock,
   input  logic          reset,
   input  avg_stage_type avg_stage,
   input  cfg_type       cfg,
   output logic          rsp_push,
   output rsp_type       rsp_word
);

   localparam int WARM_W    = $clog2(WARMUP_SAMPLES + 1);
   localparam int HOLD_LOAD = HOLD_SECONDS * SAMPLE_RATE;
   localparam int HOLD_W    = $clog2(HOLD_LOAD + 1);
   localparam logic [WARM_W-1:0] WARM_TARGET = WARM_W'(WARMUP_SAMPLES);
   localparam logic [HOLD_W-1:0] HOLD_INIT   = HOLD_W'(HOLD_LOAD);
   localparam logic [15:0]       LIMIT       = 16'(THRESHOLD_LIMIT);
   localparam logic [FAULT_W-1:0] FAULT_RESET = FAULT_W'(1) << FB_PIN;

   logic [FAULT_W-1:0]        fault_ff, fault_in;
   logic [FAULT_W-1:0]        last_ff;
   logic signed [ANGLE_W-1:0] pitch_ff, pitch_in;
   logic signed [ANGLE_W-1:0] roll_ff, roll_in;
   logic [WARM_W-1:0]         warm_ff, warm_in;
   logic [HOLD_W-1:0]         hold_ff, hold_in, hold_base;
   logic                      fire_ff, fire_in;
   logic signed [TEMP_W:0]    temp_x;
   logic signed [TEMP_W:0]    protect_x;
   logic signed [TEMP_W:0]    recovery_x;
   logic                      detect_on;
   logic                      trigger;
   item_type                  item;

   assign item       = avg_stage.item;
   assign temp_x     = {item.head_temp[TEMP_W-1], item.head_temp};
   assign protect_x  = $signed({2'b00, cfg.protect_temp});
   assign recovery_x = $signed({2'b00, cfg.recovery_temp});

   // fault word; fire bit uses the flag from the previous sample
   always_comb begin
      fault_in = fault_ff;
      pitch_in = pitch_ff;
      roll_in  = roll_ff;
      if (item.pin_confirm) begin
         fault_in[FB_PIN] = 1'b0;
      end
      if (cfg.imu_absent) begin
         fault_in[FB_IMU] = 1'b1;
      end
      if (!fault_in[FB_IMU] && item.attitude_valid) begin
         pitch_in = item.pitch_deg;
         roll_in  = item.roll_deg;
      end
      if (temp_x > protect_x) begin
         fault_in[FB_TEMP] = 1'b1;
      end else if (temp_x < recovery_x) begin
         fault_in[FB_TEMP] = 1'b0;
      end
      fault_in[FB_ATT]  = ($signed(roll_in) <= $signed(cfg.roll_low))
                       || ($signed(roll_in) >= $signed(cfg.roll_high))
                       || ($signed(pitch_in) <= $signed(cfg.pitch_low))
                       || ($signed(pitch_in) >= $signed(cfg.pitch_high));
      fault_in[FB_FAN]  = !item.fan_ok;
      fault_in[FB_FIRE] = fire_ff;
   end

   // flame detector
   assign detect_on = (cfg.fire_threshold <= LIMIT);
   assign trigger   = detect_on && ({4'b0000, avg_stage.avg} <= cfg.fire_threshold);
   assign hold_base = detect_on ? hold_ff : '0;

   always_comb begin
      warm_in = warm_ff;
      hold_in = hold_ff;
      fire_in = fire_ff;
      if (warm_ff < WARM_TARGET) begin
         warm_in = warm_ff + 1'b1;
      end
      if (warm_in >= WARM_TARGET) begin
         if (trigger) begin
            fire_in = 1'b1;
            hold_in = HOLD_INIT;
         end else if (hold_base != '0) begin
            hold_in = hold_base - 1'b1;
         end else begin
            hold_in = hold_base;
            fire_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff <= FAULT_RESET;
         last_ff  <= '0;
         pitch_ff <= '0;
         roll_ff  <= '0;
         warm_ff  <= '0;
         hold_ff  <= '0;
         fire_ff  <= 1'b0;
      end else if (avg_stage.valid) begin
         fault_ff <= fault_in;
         last_ff  <= fault_in;
         pitch_ff <= pitch_in;
         roll_ff  <= roll_in;
         warm_ff  <= warm_in;
         hold_ff  <= hold_in;
         fire_ff  <= fire_in;
      end
   end

   assign rsp_push               = avg_stage.valid;
   assign rsp_word.fault_word    = fault_in;
   assign rsp_word.force_off     = (fault_in != '0);
   assign rsp_word.fault_changed = (fault_in != last_ff);
   assign rsp_word.fire_flag     = fire_in;
   assign rsp_word.flame_average = avg_stage.avg;

endmodule

/* rtl/lsfm_rsp_fifo.sv */
// ---------------------------------------------------------------------------
// lsfm_rsp_fifo
// Response queue; absorbs words in flight while the consumer stalls.
// ---------------------------------------------------------------------------
module lsfm_rsp_fifo import lsfm_pkg::*; #(
   parameter int DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  rsp_type                      push_data,
   input  logic                         pop,
   output logic                         out_valid,
   output rsp_type                      out_data,
   output logic [$clog2(DEPTH+1)-1:0]   count
);

   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam logic [ADDR_W-1:0] LAST = ADDR_W'(DEPTH - 1);

   rsp_type           entry_ff [DEPTH];
   logic [ADDR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

/* rtl/lsfm_checker.sv */
// ---------------------------------------------------------------------------
// lsfm_checker
// Port-level checks on the response stream, bound to the top level.
// ---------------------------------------------------------------------------
`include "laser_safety_fault_monitor_assert.svh"

module lsfm_checker import lsfm_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [FAULT_W-1:0]        rsp_fault_word,
   input logic                      rsp_force_off,
   input logic                      rsp_fire_flag,
   input logic [FLAME_W-1:0]        rsp_flame_average
);

   logic rsp_fire;
   logic pin_clear_ff;
   logic imu_seen_ff;
   logic prev_fire_ff;

   assign rsp_fire = rsp_valid & rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pin_clear_ff <= 1'b0;
         imu_seen_ff  <= 1'b0;
         prev_fire_ff <= 1'b0;
      end else if (rsp_fire) begin
         pin_clear_ff <= pin_clear_ff | !rsp_fault_word[FB_PIN];
         imu_seen_ff  <= imu_seen_ff | rsp_fault_word[FB_IMU];
         prev_fire_ff <= rsp_fire_flag;
      end
   end

   `LSFM_ASSERT_SAME(a_force_off_match, rsp_valid,
      rsp_force_off == (rsp_fault_word != '0), "force_off does not match fault word")
   `LSFM_ASSERT_SAME(a_pin_stays_clear, rsp_valid && pin_clear_ff,
      !rsp_fault_word[FB_PIN], "pin fault set again after clear")
   `LSFM_ASSERT_SAME(a_imu_sticky, rsp_valid && imu_seen_ff,
      rsp_fault_word[FB_IMU], "imu fault dropped")
   `LSFM_ASSERT_SAME(a_fire_bit_lag, rsp_valid,
      rsp_fault_word[FB_FIRE] == prev_fire_ff, "fire bit not previous fire flag")
   `LSFM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_fault_word) && $stable(rsp_flame_average),
      "stalled response word changed")

endmodule

bind laser_safety_fault_monitor lsfm_checker u_lsfm_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_fault_word    (rsp_fault_word),
   .rsp_force_off     (rsp_force_off),
   .rsp_fire_flag     (rsp_fire_flag),
   .rsp_flame_average (rsp_flame_average)
);

/* sim/tb_laser_safety_fault_monitor.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_laser_safety_fault_monitor
// Self-checking bench for the laser head safety monitor. A clocked driver
// feeds sample words from a queue and a clocked monitor takes report words.
// Both sides insert random gaps. Every accepted sample runs through a local
// model of the fault word, the flame window and the fire hold counter. Each
// report word is checked field by field against the oldest prediction.
// Phases walk through temperature hysteresis, the attitude window, warm-up,
// fire hold and release, detection disabled, and the sticky IMU fault.
// ---------------------------------------------------------------------------
module tb_laser_safety_fault_monitor;
   import lsfm_pkg::*;

   // block configuration, kept at the design defaults
   localparam int WINDOW_DEPTH    = 64;
   localparam int WARMUP_SAMPLES  = 380;
   localparam int SAMPLE_RATE     = 100;
   localparam int THRESHOLD_LIMIT = 4000;

   // window stage count, used to pad the idle wait before CSR writes
   localparam int PIPE_LATENCY = 3;
   // cycles with no word moving on either side before the run is abandoned
   localparam int STALL_LIMIT  = 4000;
   // CSR index with no register behind it; the write must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 4'd12;

   // one sample period as seen on the request channel
   typedef struct packed {
      logic [FLAME_W-1:0]        flame_sample;
      logic signed [TEMP_W-1:0]  head_temp;
      logic signed [ANGLE_W-1:0] pitch_deg;
      logic signed [ANGLE_W-1:0] roll_deg;
      logic                      attitude_valid;
      logic                      fan_ok;
      logic                      pin_confirm;
   } sample_word_type;

   // ------------------------------------------------------------------------
   // DUT connections; every input starts at a known value
   // ------------------------------------------------------------------------
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [FLAME_W-1:0]        req_flame_sample = '0;
   logic signed [TEMP_W-1:0]  req_head_temp = '0;
   logic signed [ANGLE_W-1:0] req_pitch_deg = '0;
   logic signed [ANGLE_W-1:0] req_roll_deg = '0;
   logic                      req_attitude_valid = 1'b0;
   logic                      req_fan_ok = 1'b0;
   logic                      req_pin_confirm = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [FAULT_W-1:0]        rsp_fault_word;
   logic                      rsp_force_off;
   logic                      rsp_fault_changed;
   logic                      rsp_fire_flag;
   logic [FLAME_W-1:0]        rsp_flame_average;
   logic                      csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = '0;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   laser_safety_fault_monitor #(
      .WINDOW_DEPTH    (WINDOW_DEPTH),
      .WARMUP_SAMPLES  (WARMUP_SAMPLES),
      .SAMPLE_RATE     (SAMPLE_RATE),
      .THRESHOLD_LIMIT (THRESHOLD_LIMIT)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_flame_sample   (req_flame_sample),
      .req_head_temp      (req_head_temp),
      .req_pitch_deg      (req_pitch_deg),
      .req_roll_deg       (req_roll_deg),
      .req_attitude_valid (req_attitude_valid),
      .req_fan_ok         (req_fan_ok),
      .req_pin_confirm    (req_pin_confirm),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_fault_word     (rsp_fault_word),
      .rsp_force_off      (rsp_force_off),
      .rsp_fault_changed  (rsp_fault_changed),
      .rsp_fire_flag      (rsp_fire_flag),
      .rsp_flame_average  (rsp_flame_average),
      .csr_wr_en          (csr_wr_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Bench state
   // ------------------------------------------------------------------------
   sample_word_type sample_queue[$];      // words not yet offered
   rsp_type         expected_reports[$];  // predictions awaiting a report word
   sample_word_type cur_word = '0;        // word on the request ports
   bit              req_busy = 1'b0;      // cur_word offered, not yet taken
   bit              req_taken = 1'b0;     // handshake seen at the last rise
   bit              rsp_taken = 1'b0;
   bit              req_burst = 1'b0;     // burst mode: no gaps at all
   bit              rsp_burst = 1'b0;
   int              req_wait = 0;
   int              rsp_wait = 0;
   int              idle_cycles = 0;
   int              fail_count = 0;

   // ------------------------------------------------------------------------
   // Local copy of the monitor: registers and per-period state
   // ------------------------------------------------------------------------
   cfg_type            cur_cfg;
   logic [FAULT_W-1:0] m_fault = 6'b010000;   // pin fault set out of reset
   logic [FAULT_W-1:0] m_last_fault = '0;
   int                 m_pitch = 0;
   int                 m_roll = 0;
   int                 m_window [WINDOW_DEPTH] = '{default: 0};
   int                 m_sum = 0;
   int                 m_ptr = 0;
   int                 m_warm = 0;
   int                 m_hold = 0;
   bit                 m_fire = 1'b0;

   // One sample period. Order matters: pin confirm, then the fault word
   // (which sees the fire latch from the previous period), then the window.
   function automatic rsp_type evaluate_period(sample_word_type w);
      rsp_type rep;
      int      temp;
      int      avg;
      bit      trigger;
      temp    = int'($signed(w.head_temp));
      trigger = 1'b0;

      if (w.pin_confirm)
         m_fault[FB_PIN] = 1'b0;
      if (cur_cfg.imu_absent)
         m_fault[FB_IMU] = 1'b1;

      // attitude is frozen once the IMU fault is up
      if (!m_fault[FB_IMU] && w.attitude_valid) begin
         m_pitch = int'($signed(w.pitch_deg));
         m_roll  = int'($signed(w.roll_deg));
      end

      // hysteresis: set test first, so it wins if the limits cross
      if (temp > int'(cur_cfg.protect_temp))
         m_fault[FB_TEMP] = 1'b1;
      else if (temp < int'(cur_cfg.recovery_temp))
         m_fault[FB_TEMP] = 1'b0;

      m_fault[FB_ATT] = (m_roll <= int'($signed(cur_cfg.roll_low))) ||
                        (m_roll >= int'($signed(cur_cfg.roll_high))) ||
                        (m_pitch <= int'($signed(cur_cfg.pitch_low))) ||
                        (m_pitch >= int'($signed(cur_cfg.pitch_high)));
      m_fault[FB_FAN]  = !w.fan_ok;
      m_fault[FB_FIRE] = m_fire;   // one period behind fire_flag

      rep.fault_word    = m_fault;
      rep.force_off     = |m_fault;
      rep.fault_changed = (m_fault != m_last_fault);
      m_last_fault      = m_fault;

      // running-sum window, empty slots count as zero
      m_sum = m_sum - m_window[m_ptr] + int'(w.flame_sample);
      m_window[m_ptr] = int'(w.flame_sample);
      m_ptr = (m_ptr + 1) % WINDOW_DEPTH;
      avg = m_sum / WINDOW_DEPTH;

      if (m_warm < WARMUP_SAMPLES)
         m_warm++;
      if (m_warm >= WARMUP_SAMPLES) begin
         if (int'(cur_cfg.fire_threshold) <= THRESHOLD_LIMIT)
            trigger = (avg <= int'(cur_cfg.fire_threshold));
         else
            m_hold = 0;   // disabled: drop the hold, latch clears below
         if (trigger) begin
            m_fire = 1'b1;
            m_hold = HOLD_SECONDS * SAMPLE_RATE;
         end else if (m_hold != 0) begin
            m_hold--;
         end else begin
            m_fire = 1'b0;
         end
      end

      rep.fire_flag     = m_fire;
      rep.flame_average = avg[FLAME_W-1:0];
      return rep;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic sample_word_type make_sample(int flame, int temp, int pitch, int roll,
                                                   bit att_valid, bit fan, bit pin);
      sample_word_type s;
      s.flame_sample   = flame[FLAME_W-1:0];
      s.head_temp      = temp[TEMP_W-1:0];
      s.pitch_deg      = pitch[ANGLE_W-1:0];
      s.roll_deg       = roll[ANGLE_W-1:0];
      s.attitude_valid = att_valid;
      s.fan_ok         = fan;
      s.pin_confirm    = pin;
      return s;
   endfunction

   // Random period: flame mostly within [lo, hi], temperature half the time
   // near the hysteresis band, angles mostly around the default window.
   function automatic sample_word_type rand_sample(int lo, int hi, bit noisy);
      int flame;
      int temp;
      int t_lo;
      int t_hi;
      int pitch;
      int roll;
      if (noisy && $urandom_range(0, 15) == 0)
         flame = $urandom_range(0, 4095);
      else
         flame = lo + int'($urandom_range(0, hi - lo));

      t_lo = int'(cur_cfg.protect_temp);
      t_hi = int'(cur_cfg.recovery_temp);
      if (t_lo > t_hi) begin
         t_lo = int'(cur_cfg.recovery_temp);
         t_hi = int'(cur_cfg.protect_temp);
      end
      t_lo = (t_lo - 6 < -128) ? -128 : t_lo - 6;
      t_hi = (t_hi + 6 > 255) ? 255 : t_hi + 6;
      if ($urandom_range(0, 1))
         temp = int'($urandom_range(0, 383)) - 128;
      else
         temp = t_lo + int'($urandom_range(0, t_hi - t_lo));

      if ($urandom_range(0, 3) != 0) begin
         pitch = int'($urandom_range(0, 140)) - 70;
         roll  = int'($urandom_range(0, 140)) - 70;
      end else begin
         pitch = int'($urandom_range(0, 360)) - 180;
         roll  = int'($urandom_range(0, 360)) - 180;
      end
      return make_sample(flame, temp, pitch, roll, $urandom_range(0, 1),
                         $urandom_range(0, 9) != 0, $urandom_range(0, 7) == 0);
   endfunction

   task automatic run_phase(int count, int lo, int hi, bit noisy);
      repeat (count) sample_queue.push_back(rand_sample(lo, hi, noisy));
   endtask

   // wait for all outstanding words plus pipeline slack before touching CSRs
   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_busy || expected_reports.size() != 0)
         @(posedge clock);
      repeat (PIPE_LATENCY * 4) @(posedge clock);
   endtask

   // one CSR write; the model sees the same masking as the register file
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         CSR_PROTECT_TEMP:   cur_cfg.protect_temp   = data[7:0];
         CSR_RECOVERY_TEMP:  cur_cfg.recovery_temp  = data[7:0];
         CSR_FIRE_THRESHOLD: cur_cfg.fire_threshold = data[15:0];
         CSR_ROLL_LOW:       cur_cfg.roll_low       = data[ANGLE_W-1:0];
         CSR_ROLL_HIGH:      cur_cfg.roll_high      = data[ANGLE_W-1:0];
         CSR_PITCH_LOW:      cur_cfg.pitch_low      = data[ANGLE_W-1:0];
         CSR_PITCH_HIGH:     cur_cfg.pitch_high     = data[ANGLE_W-1:0];
         CSR_IMU_ABSENT:     cur_cfg.imu_absent     = data[0];
         default: ;
      endcase
   endtask

   // full register set; unused upper data bits carry junk
   task automatic set_config(int prot, int rec, int thr, int rl, int rh,
                             int pl, int ph, bit imu);
      write_csr(CSR_PROTECT_TEMP,   {8'($urandom), prot[7:0]});
      write_csr(CSR_RECOVERY_TEMP,  {8'($urandom), rec[7:0]});
      write_csr(CSR_FIRE_THRESHOLD, thr[15:0]);
      write_csr(CSR_ROLL_LOW,       {7'($urandom), rl[ANGLE_W-1:0]});
      write_csr(CSR_ROLL_HIGH,      {7'($urandom), rh[ANGLE_W-1:0]});
      write_csr(CSR_PITCH_LOW,      {7'($urandom), pl[ANGLE_W-1:0]});
      write_csr(CSR_PITCH_HIGH,     {7'($urandom), ph[ANGLE_W-1:0]});
      write_csr(CSR_IMU_ABSENT,     {15'($urandom), imu});
   endtask

   // ------------------------------------------------------------------------
   // Request driver: takes handshakes at the rise, drives at the fall
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_reports.push_back(evaluate_period(cur_word));
         req_taken = 1'b1;
      end
   end

   always @(negedge clock) begin
      if (!reset) begin
         if (req_taken) begin
            req_taken = 1'b0;
            req_busy  = 1'b0;
         end
         // gap counts down only while there is a word to send
         if (!req_busy && sample_queue.size() != 0) begin
            if (req_wait == 0) begin
               cur_word = sample_queue.pop_front();
               req_busy = 1'b1;
               if ($urandom_range(0, 49) == 0)
                  req_burst = !req_burst;
               req_wait = req_burst ? 0 : $urandom_range(0, 7);
            end else begin
               req_wait--;
            end
         end
         // valid stays up across back-to-back words: one assignment per fall
         req_valid          <= req_busy;
         req_flame_sample   <= cur_word.flame_sample;
         req_head_temp      <= cur_word.head_temp;
         req_pitch_deg      <= cur_word.pitch_deg;
         req_roll_deg       <= cur_word.roll_deg;
         req_attitude_valid <= cur_word.attitude_valid;
         req_fan_ok         <= cur_word.fan_ok;
         req_pin_confirm    <= cur_word.pin_confirm;
      end
   end

   // ------------------------------------------------------------------------
   // Report monitor and checker
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_taken = 1'b1;
         if (expected_reports.size() == 0) begin
            $error("report word with nothing expected, fault_word %0h", rsp_fault_word);
            fail_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_fault_word !== want.fault_word) begin
               $error("fault_word expected %0h actual %0h", want.fault_word, rsp_fault_word);
               fail_count++;
            end
            if (rsp_force_off !== want.force_off) begin
               $error("force_off expected %0b actual %0b", want.force_off, rsp_force_off);
               fail_count++;
            end
            if (rsp_fault_changed !== want.fault_changed) begin
               $error("fault_changed expected %0b actual %0b",
                      want.fault_changed, rsp_fault_changed);
               fail_count++;
            end
            if (rsp_fire_flag !== want.fire_flag) begin
               $error("fire_flag expected %0b actual %0b", want.fire_flag, rsp_fire_flag);
               fail_count++;
            end
            if (rsp_flame_average !== want.flame_average) begin
               $error("flame_average expected %0d actual %0d",
                      want.flame_average, rsp_flame_average);
               fail_count++;
            end
         end
      end
   end

   // consumer stall: drawn after each taken word
   always @(negedge clock) begin
      if (!reset) begin
         if (rsp_taken) begin
            rsp_taken = 1'b0;
            if ($urandom_range(0, 49) == 0)
               rsp_burst = !rsp_burst;
            rsp_wait = rsp_burst ? 0 : $urandom_range(0, 7);
         end
         if (rsp_wait != 0) begin
            rsp_wait--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: nothing moving for too long means a hang
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int prot;
      int rec;
      int thr;
      int lo;
      int hi;

      cur_cfg.protect_temp   = 8'd55;
      cur_cfg.recovery_temp  = 8'd45;
      cur_cfg.fire_threshold = 16'd1000;
      cur_cfg.roll_low       = -9'sd45;
      cur_cfg.roll_high      = 9'sd45;
      cur_cfg.pitch_low      = -9'sd45;
      cur_cfg.pitch_high     = 9'sd45;
      cur_cfg.imu_absent     = 1'b0;

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset configuration: pin fault visible first
      sample_queue.push_back(make_sample(0,    0,    0,    0,    1, 1, 0));
      // temperature band: above protect sets, inside holds, below recovery clears
      sample_queue.push_back(make_sample(4095, 56,   0,    0,    0, 1, 0));
      sample_queue.push_back(make_sample(4095, 50,   0,    0,    0, 1, 0));
      sample_queue.push_back(make_sample(4095, 45,   0,    0,    0, 1, 0));
      sample_queue.push_back(make_sample(4095, 44,   0,    0,    0, 1, 0));
      sample_queue.push_back(make_sample(4095, 55,   0,    0,    0, 1, 0));
      sample_queue.push_back(make_sample(0,    255,  0,    0,    0, 1, 0));
      sample_queue.push_back(make_sample(0,    -128, 0,    0,    0, 1, 0));
      // attitude window edges, which count as outside on both sides
      sample_queue.push_back(make_sample(2048, 20,   45,   0,    1, 1, 0));
      sample_queue.push_back(make_sample(2048, 20,   44,   -44,  1, 1, 0));
      sample_queue.push_back(make_sample(2048, 20,   -44,  -45,  1, 1, 0));
      sample_queue.push_back(make_sample(2048, 20,   -45,  44,   1, 1, 0));
      sample_queue.push_back(make_sample(1,    20,   -180, 180,  1, 1, 0));
      // stale angles ignored when attitude_valid is low
      sample_queue.push_back(make_sample(4094, 20,   0,    0,    0, 1, 0));
      sample_queue.push_back(make_sample(4095, 20,   180,  -180, 1, 1, 0));
      sample_queue.push_back(make_sample(4095, 20,   10,   -10,  1, 1, 0));
      // fan fault, then pin confirm clears the pin bit for good
      sample_queue.push_back(make_sample(4095, 20,   10,   -10,  0, 0, 0));
      sample_queue.push_back(make_sample(4095, 20,   10,   -10,  0, 1, 1));
      sample_queue.push_back(make_sample(4095, 20,   10,   -10,  0, 1, 0));
      sample_queue.push_back(make_sample(4095, 20,   10,   -10,  0, 1, 0));
      sample_queue.push_back(make_sample(2730, 46,   -1,   1,    1, 0, 1));
      sample_queue.push_back(make_sample(1365, 46,   0,    0,    1, 1, 0));

      // warm-up runs out here with a low flame level: fire rises
      wait_idle();
      set_config(60, 40, 1000, -45, 45, -45, 45, 1'b0);
      run_phase(400, 0, 1500, 1'b1);

      // just above the limit: detection disabled, latched flag drops at once
      wait_idle();
      set_config(255, 0, THRESHOLD_LIMIT + 1, -180, 180, -180, 180, 1'b0);
      run_phase(100, 0, 4095, 1'b1);

      // crossed temperature limits (set wins), tight window, threshold at limit
      wait_idle();
      set_config(0, 255, THRESHOLD_LIMIT, -1, 1, -1, 1, 1'b0);
      run_phase(150, 0, 4095, 1'b1);

      // zero threshold and bright flame: hold counter runs out and releases
      wait_idle();
      set_config(90, 70, 0, -90, 90, -60, 60, 1'b0);
      run_phase(600, 1500, 4095, 1'b1);

      // write to an unmapped index must change nothing; full-scale threshold
      wait_idle();
      write_csr(CSR_UNMAPPED, 16'($urandom));
      set_config(30, 20, 65535, -180, 180, -180, 180, 1'b0);
      run_phase(100, 0, 100, 1'b1);

      // dark sensor with zero threshold: average reaches zero and triggers
      wait_idle();
      set_config(120, 100, 0, -60, 60, -60, 60, 1'b0);
      run_phase(80, 0, 0, 1'b0);

      // random registers, flame hovering around the threshold
      wait_idle();
      prot = $urandom_range(20, 120);
      rec  = prot - int'($urandom_range(0, 20));
      thr  = $urandom_range(0, THRESHOLD_LIMIT);
      lo   = (thr < 300) ? 0 : thr - 300;
      hi   = (thr + 300 > 4095) ? 4095 : thr + 300;
      set_config(prot, rec, thr, -int'($urandom_range(10, 90)), $urandom_range(10, 90),
                 -int'($urandom_range(10, 90)), $urandom_range(10, 90), 1'b0);
      run_phase(200, lo, hi, 1'b1);

      // IMU missing: sticky fault, attitude frozen
      wait_idle();
      set_config(prot, rec, thr, -45, 45, -45, 45, 1'b1);
      run_phase(100, lo, hi, 1'b1);

      // clearing the register leaves the IMU fault in place
      wait_idle();
      set_config(55, 45, THRESHOLD_LIMIT + 1, -30, 30, -30, 30, 1'b0);
      run_phase(100, 0, 4095, 1'b1);

      wait_idle();
      if (fail_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
